### design/stcc_pkg.sv
// ----------------------------------------------------------------------------
// stcc_pkg
// shared types and constants for the soft takeover cc controller
// ----------------------------------------------------------------------------
package stcc_pkg;

    localparam int TRACKS = 4;
    localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    localparam int POT_W  = 12;
    localparam int CC_W   = 7;
    localparam int CHAN_W = 5;
    localparam int CTRL_W = 5;
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] CFG_VALUE_CH  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ARM_CH    = 2'd2;

    localparam logic [CC_W-1:0]   THRESHOLD_RST = 7'd2;
    localparam logic [CHAN_W-1:0] VALUE_CH_RST  = 5'd1;
    localparam logic [CHAN_W-1:0] ARM_CH_RST    = 5'd2;
    localparam logic [TRK_W-1:0]  SEL_RST       = TRK_W'(1);
    localparam logic [TRK_W-1:0]  SEL_MAX       = TRK_W'(TRACKS - 1);

    localparam logic [CC_W-1:0] ARM_ON_VAL  = 7'd127;
    localparam logic [CC_W-1:0] ARM_OFF_VAL = 7'd0;

    // one control change transaction
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [CTRL_W-1:0] ctrl;
        logic [CC_W-1:0]   val;
        logic              last;
    } result_t;

    // push request toward the output queue
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

### design/stcc_scale.sv
// ----------------------------------------------------------------------------
// stcc_scale
// scales a 12-bit pot sample to 0..127 as sample*127/4095, truncated
// ----------------------------------------------------------------------------
module stcc_scale (
    input  logic [stcc_pkg::POT_W-1:0] raw,
    output logic [stcc_pkg::CC_W-1:0]  pot
);

    logic [18:0] prod;
    logic [6:0]  q0;
    logic [12:0] rem;

    // x/4095 = x>>12 plus one when low part plus quotient reaches 4095
    always_comb
    begin
        prod = {raw, 7'b0} - {7'b0, raw};
        q0   = prod[18:12];
        rem  = {1'b0, prod[11:0]} + {6'b0, q0};
        if (rem >= 13'd4095)
        begin
            pot = q0 + 7'd1;
        end
        else
        begin
            pot = q0;
        end
    end

endmodule

### design/stcc_out_queue.sv
// ----------------------------------------------------------------------------
// stcc_out_queue
// four-entry result queue, takes up to two a cycle, sends one unless stalled
// ----------------------------------------------------------------------------
module stcc_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  stcc_pkg::push_t     push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_stall,
    output stcc_pkg::result_t   head
);

    stcc_pkg::result_t entry_reg [4];
    logic [1:0] wr_reg;
    logic [1:0] wr_next;
    logic [1:0] rd_reg;
    logic [1:0] rd_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;
    logic [1:0] wr_plus1;
    logic [2:0] n_push;

    assign out_valid = (count_reg != 3'd0);
    assign head      = entry_reg[rd_reg];
    assign room      = (count_reg <= 3'd2);
    assign pop       = out_valid && !out_stall;
    assign wr_plus1  = wr_reg + 2'd1;

    always_comb
    begin
        n_push     = {2'b0, push.push0} + {2'b0, push.push1};
        wr_next    = wr_reg + n_push[1:0];
        rd_next    = pop ? rd_reg + 2'd1 : rd_reg;
        count_next = count_reg + n_push - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 2'd0;
            rd_reg    <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry_reg[wr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            entry_reg[wr_plus1] <= push.res1;
        end
    end

endmodule

### design/soft_takeover_cc_controller_core.sv
// ----------------------------------------------------------------------------
// soft_takeover_cc_controller_core
// pedal poll to midi control change transactions with soft takeover per track
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------
//   in      | in_valid / in_stall   | left_level right_level pot_sample
//           |                       | arm_level
//   out     | out_valid / out_stall | midi_channel controller_number cc_value
//           |                       | last
//   cfg     | cfg_write             | cfg_index cfg_data
//
// a poll is registered, then handled once the queue has room; that step
// updates the track state and queues zero, one or two transactions. the output
// port sends one transaction a cycle while out_stall is low. the four-entry
// output queue takes a poll only with room for two results, so in_stall
// follows queue fill and never out_stall directly. reset clears all control
// state and track state to its start values.
// ----------------------------------------------------------------------------
module soft_takeover_cc_controller_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [stcc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [stcc_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          left_level,
    input  logic                          right_level,
    input  logic [stcc_pkg::POT_W-1:0]    pot_sample,
    input  logic                          arm_level,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [stcc_pkg::CHAN_W-1:0]   midi_channel,
    output logic [stcc_pkg::CTRL_W-1:0]   controller_number,
    output logic [stcc_pkg::CC_W-1:0]     cc_value,
    output logic                          last
);

    // configuration
    logic [stcc_pkg::CC_W-1:0]   threshold_reg;
    logic [stcc_pkg::CHAN_W-1:0] value_ch_reg;
    logic [stcc_pkg::CHAN_W-1:0] arm_ch_reg;

    // input register
    logic                        full_reg;
    logic                        full_next;
    logic                        left_reg;
    logic                        right_reg;
    logic [stcc_pkg::POT_W-1:0]  raw_reg;
    logic                        arm_reg;

    // track state
    logic [stcc_pkg::TRK_W-1:0]  sel_reg;
    logic [stcc_pkg::TRK_W-1:0]  sel_next;
    logic                        prior_left_reg;
    logic                        prior_right_reg;
    logic [stcc_pkg::TRACKS-1:0] live_reg;
    logic [stcc_pkg::TRACKS-1:0] live_next;
    logic [stcc_pkg::TRACKS-1:0] live_upd;
    logic [stcc_pkg::CC_W-1:0]   tval_reg [stcc_pkg::TRACKS];
    logic [stcc_pkg::CC_W-1:0]   sent_reg [stcc_pkg::TRACKS];
    logic [stcc_pkg::TRACKS-1:0] sent_ok_reg;
    logic [stcc_pkg::TRACKS-1:0] armed_reg;

    logic                        room;
    logic                        process;
    logic [stcc_pkg::TRK_W-1:0]  sel_mid;
    logic [stcc_pkg::CC_W-1:0]   pot;
    logic [stcc_pkg::CC_W-1:0]   stored;
    logic [stcc_pkg::CC_W-1:0]   pot_gap;
    logic                        go;
    logic                        emit_val;
    logic                        emit_arm;
    logic [stcc_pkg::CTRL_W-1:0] ctrl;
    stcc_pkg::result_t           val_res;
    stcc_pkg::result_t           arm_res;
    stcc_pkg::push_t             push;
    stcc_pkg::result_t           head;

    assign process   = full_reg && room;
    assign in_stall  = full_reg && !room;
    assign full_next = (in_valid && !in_stall) || (full_reg && !process);

    stcc_scale u_scale (
        .raw (raw_reg),
        .pot (pot)
    );

    // selection moves and pickup locks, left before right
    always_comb
    begin
        live_next = live_reg;
        sel_mid   = sel_reg;
        if ((left_reg != prior_left_reg) && (sel_reg != '0))
        begin
            sel_mid            = sel_reg - stcc_pkg::TRK_W'(1);
            live_next[sel_mid] = 1'b0;
        end
        sel_next = sel_mid;
        if ((right_reg != prior_right_reg) && (sel_mid != stcc_pkg::SEL_MAX))
        begin
            sel_next            = sel_mid + stcc_pkg::TRK_W'(1);
            live_next[sel_next] = 1'b0;
        end
    end

    always_comb
    begin
        stored   = tval_reg[sel_next];
        pot_gap  = (pot > stored) ? pot - stored : stored - pot;
        go       = live_next[sel_next] || (pot_gap <= threshold_reg);
        emit_val = go && (!sent_ok_reg[sel_next] || (sent_reg[sel_next] != pot));
        emit_arm = (arm_reg != armed_reg[sel_next]);
        ctrl     = stcc_pkg::CTRL_W'(sel_next) + 5'd1;

        live_upd = live_next;
        if (go)
        begin
            live_upd[sel_next] = 1'b1;
        end

        val_res.chan = value_ch_reg;
        val_res.ctrl = ctrl;
        val_res.val  = pot;
        val_res.last = !emit_arm;

        arm_res.chan = arm_ch_reg;
        arm_res.ctrl = ctrl;
        arm_res.val  = arm_reg ? stcc_pkg::ARM_ON_VAL : stcc_pkg::ARM_OFF_VAL;
        arm_res.last = 1'b1;

        push.push0 = process && (emit_val || emit_arm);
        push.push1 = process && emit_val && emit_arm;
        push.res0  = emit_val ? val_res : arm_res;
        push.res1  = arm_res;
    end

    stcc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign midi_channel      = head.chan;
    assign controller_number = head.ctrl;
    assign cc_value          = head.val;
    assign last              = head.last;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= stcc_pkg::THRESHOLD_RST;
            value_ch_reg  <= stcc_pkg::VALUE_CH_RST;
            arm_ch_reg    <= stcc_pkg::ARM_CH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                stcc_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data;
                stcc_pkg::CFG_VALUE_CH:  value_ch_reg  <= cfg_data[stcc_pkg::CHAN_W-1:0];
                stcc_pkg::CFG_ARM_CH:    arm_ch_reg    <= cfg_data[stcc_pkg::CHAN_W-1:0];
                default:                 ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            left_reg  <= left_level;
            right_reg <= right_level;
            raw_reg   <= pot_sample;
            arm_reg   <= arm_level;
        end
    end

    // track state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg         <= stcc_pkg::SEL_RST;
            prior_left_reg  <= 1'b1;
            prior_right_reg <= 1'b1;
            live_reg        <= '0;
            sent_ok_reg     <= '0;
            armed_reg       <= '1;
            for (int i = 0; i < stcc_pkg::TRACKS; i++)
            begin
                tval_reg[i] <= '0;
                sent_reg[i] <= '0;
            end
        end
        else if (process)
        begin
            sel_reg         <= sel_next;
            prior_left_reg  <= left_reg;
            prior_right_reg <= right_reg;
            live_reg        <= live_upd;
            if (go)
            begin
                tval_reg[sel_next] <= pot;
            end
            if (emit_val)
            begin
                sent_reg[sel_next]    <= pot;
                sent_ok_reg[sel_next] <= 1'b1;
            end
            armed_reg[sel_next] <= arm_reg;
        end
    end

endmodule
